/* sv/bpjq_pkg.sv */
// Shared types and constants for the bounded priority job queue.
// No dependencies; every other file in this folder imports this package.
package bpjq_pkg;

	localparam int DEPTH  = 8;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int TAG_W  = 16;
	localparam int PRIO_W = 2;

	typedef enum logic {
		ACTION_INSERT = 1'b0,
		ACTION_REMOVE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_REMOVE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    ins_step;
		logic    rem_step;
		logic    emit;
		logic    emit_tag;
		status_t code;
	} bpjq_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic ins_final;
		logic rem_final;
	} bpjq_sts_t;

endpackage

/* sv/bounded_priority_job_queue_unit.sv */
// Top level of the bounded priority job queue.
// Depends on bpjq_pkg, bpjq_ctrl and bpjq_dp.

// A request is taken at a rising edge where start is high and busy is low; it
// either inserts a job (tag and priority, lower priority value served first,
// first in first out among equal priorities) or removes the most urgent job.
// Every request gives exactly one result, shown for a single cycle with done
// high; the receiver cannot stall, so it must capture the result in that cycle.
// A rejected request (insert while full, remove while empty) answers in the cycle
// after it is taken and never raises busy. A successful insert keeps busy high
// while it moves each queued job less urgent than the new one up a slot and
// then writes the new job; a successful remove keeps busy high while it walks
// every job that was queued before the remove, moving each one behind the head
// down a slot. The result appears in the first cycle with busy low again. The
// slot store has one registered read port and one write port, so jobs move one
// slot a cycle.
module bounded_priority_job_queue_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic [bpjq_pkg::TAG_W-1:0]   job_tag,
	input  logic [bpjq_pkg::PRIO_W-1:0]  job_priority,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [bpjq_pkg::TAG_W-1:0]   out_tag,
	output logic [bpjq_pkg::PRIO_W-1:0]  out_priority,
	output logic                         is_empty,
	output logic                         is_full
);
	import bpjq_pkg::*;

	bpjq_cmd_t cmd;
	bpjq_sts_t sts;

	// The controller sequences the slot walk; the datapath owns all storage.
	bpjq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bpjq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (action),
		.job_tag      (job_tag),
		.job_priority (job_priority),
		.done         (done),
		.status       (status),
		.out_tag      (out_tag),
		.out_priority (out_priority),
		.is_empty     (is_empty),
		.is_full      (is_full)
	);

	// A result is only ever shown once the walk has finished.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in progress");

	// An overflow can only be reported for a full queue.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_OVERFLOW) |-> is_full)
		else $error("overflow reported on a queue that is not full");

	// An underflow can only be reported for an empty queue.
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_UNDERFLOW) |-> is_empty)
		else $error("underflow reported on a queue that is not empty");

	// A rejected request carries no job.
	a_reject_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_DONE) |-> (out_tag == '0 && out_priority == '0))
		else $error("rejected request returned a job");

endmodule

/* sv/bpjq_ctrl.sv */
// Controller state machine of the bounded priority job queue.
// Depends on bpjq_pkg; drives the datapath only through command and status structs.
module bpjq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               action,
	input  bpjq_pkg::bpjq_sts_t sts,
	output bpjq_pkg::bpjq_cmd_t cmd,
	output logic               busy
);
	import bpjq_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action == ACTION_INSERT) begin
						if (!sts.full) begin
							state_nx = ST_INSERT;
						end
					end else if (!sts.empty) begin
						state_nx = ST_REMOVE;
					end
				end
			end
			ST_INSERT: begin
				if (sts.ins_final) begin
					state_nx = ST_IDLE;
				end
			end
			ST_REMOVE: begin
				if (sts.rem_final) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.code     = STATUS_DONE;
		busy         = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
				// Rejected requests answer at once without leaving idle.
				if (start && action == ACTION_INSERT && sts.full) begin
					cmd.emit = 1'b1;
					cmd.code = STATUS_OVERFLOW;
				end else if (start && action == ACTION_REMOVE && sts.empty) begin
					cmd.emit = 1'b1;
					cmd.code = STATUS_UNDERFLOW;
				end
			end
			ST_INSERT: begin
				cmd.ins_step = 1'b1;
				cmd.emit     = sts.ins_final;
			end
			ST_REMOVE: begin
				cmd.rem_step = 1'b1;
				cmd.emit     = sts.rem_final;
				cmd.emit_tag = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

/* sv/bpjq_dp.sv */
// Datapath of the bounded priority job queue: slot storage, walk cursor,
// entry count and result registers. Depends on bpjq_pkg.
module bpjq_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bpjq_pkg::bpjq_cmd_t          cmd,
	output bpjq_pkg::bpjq_sts_t          sts,
	input  logic                         action,
	input  logic [bpjq_pkg::TAG_W-1:0]   job_tag,
	input  logic [bpjq_pkg::PRIO_W-1:0]  job_priority,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [bpjq_pkg::TAG_W-1:0]   out_tag,
	output logic [bpjq_pkg::PRIO_W-1:0]  out_priority,
	output logic                         is_empty,
	output logic                         is_full
);
	import bpjq_pkg::*;

	logic [TAG_W-1:0]  slot_tags   [DEPTH];
	logic [PRIO_W-1:0] slot_prios  [DEPTH];

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nx;
	logic [CNT_W-1:0]  cur_q;
	logic [CNT_W-1:0]  cur_dec;
	logic [TAG_W-1:0]  tag_q;
	logic [PRIO_W-1:0] prio_q;
	logic [TAG_W-1:0]  head_tag_q;
	logic [PRIO_W-1:0] head_prio_q;

	logic [CNT_W-1:0]  pf_cnt;
	logic [IDX_W-1:0]  pf_idx;
	logic [IDX_W-1:0]  wr_idx;
	logic [TAG_W-1:0]  rd_tag_q;
	logic [PRIO_W-1:0] rd_prio_q;
	logic [TAG_W-1:0]  wr_tag;
	logic [PRIO_W-1:0] wr_prio;
	logic              shift_up;
	logic              wr_en;

	logic              done_q;
	status_t           status_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic              empty_q;
	logic              full_q;

	assign cur_dec = cur_q - CNT_W'(1);

	// The store is read through a register, so the slot that the next step
	// needs is addressed while the current step runs. Insert looks one slot below the
	// cursor, remove looks at it.
	always_comb begin
		if (cmd.load) begin
			pf_cnt = (action == ACTION_INSERT) ? (count_q - CNT_W'(1)) : CNT_W'(1);
		end else if (cmd.ins_step) begin
			pf_cnt = cur_q - CNT_W'(2);
		end else begin
			pf_cnt = cur_q + CNT_W'(1);
		end
	end

	assign pf_idx = pf_cnt[IDX_W-1:0];

	assign shift_up = (cur_q != '0) && (rd_prio_q > prio_q);

	assign sts.full      = (count_q == CNT_W'(DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.ins_final = !shift_up;
	assign sts.rem_final = (cur_q >= count_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = cur_q[IDX_W-1:0];
		wr_tag  = rd_tag_q;
		wr_prio = rd_prio_q;
		if (cmd.ins_step) begin
			wr_en = 1'b1;
			if (!shift_up) begin
				wr_tag  = tag_q;
				wr_prio = prio_q;
			end
		end else if (cmd.rem_step && !sts.rem_final) begin
			wr_en  = 1'b1;
			wr_idx = cur_dec[IDX_W-1:0];
		end
	end

	always_comb begin
		count_nx = count_q;
		if (cmd.ins_step && sts.ins_final) begin
			count_nx = count_q + CNT_W'(1);
		end else if (cmd.rem_step && sts.rem_final) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_tags[wr_idx]  <= wr_tag;
			slot_prios[wr_idx] <= wr_prio;
		end
	end

	always_ff @(posedge clk) begin
		rd_tag_q  <= slot_tags[pf_idx];
		rd_prio_q <= slot_prios[pf_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q       <= job_tag;
			prio_q      <= job_priority;
			head_tag_q  <= slot_tags[0];
			head_prio_q <= slot_prios[0];
			cur_q       <= (action == ACTION_INSERT) ? count_q : CNT_W'(1);
		end else if (cmd.ins_step) begin
			cur_q <= cur_dec;
		end else if (cmd.rem_step) begin
			cur_q <= cur_q + CNT_W'(1);
		end
		if (cmd.emit) begin
			status_q   <= cmd.code;
			out_tag_q  <= cmd.emit_tag ? head_tag_q : '0;
			out_prio_q <= cmd.emit_tag ? head_prio_q : '0;
			empty_q    <= (count_nx == '0);
			full_q     <= (count_nx == CNT_W'(DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nx;
			done_q  <= cmd.emit;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_tag      = out_tag_q;
	assign out_priority = out_prio_q;
	assign is_empty     = empty_q;
	assign is_full      = full_q;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bounded priority job queue unit.
// Depends on bpjq_pkg and bounded_priority_job_queue_unit.
module testbench;
	import bpjq_pkg::*;

	typedef struct {
		action_t             act;
		logic [TAG_W-1:0]    tag;
		logic [PRIO_W-1:0]   prio;
		int                  gap;
		bit                  drain;
	} job_request_t;

	typedef struct {
		status_t             status;
		logic [TAG_W-1:0]    tag;
		logic [PRIO_W-1:0]   prio;
		logic                empty;
		logic                full;
	} queue_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                action = ACTION_INSERT;
	logic [TAG_W-1:0]    job_tag = '0;
	logic [PRIO_W-1:0]   job_priority = '0;
	logic                busy;
	logic                done;
	logic [1:0]          status;
	logic [TAG_W-1:0]    out_tag;
	logic [PRIO_W-1:0]   out_priority;
	logic                is_empty;
	logic                is_full;

	job_request_t        pending_requests[$];
	queue_result_t       expected_results[$];
	int                  mismatch_count = 0;
	bit                  next_armed = 1'b0;
	int                  hold_off = 0;

	// Shadow copy of the queue contents, ordered most urgent first.
	logic [TAG_W-1:0]    shadow_tags[DEPTH];
	logic [PRIO_W-1:0]   shadow_prios[DEPTH];
	int                  shadow_count = 0;

	bounded_priority_job_queue_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.job_tag(job_tag),
		.job_priority(job_priority),
		.done(done),
		.status(status),
		.out_tag(out_tag),
		.out_priority(out_priority),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic add_request(action_t act, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
			int gap, bit drain);
		job_request_t req;
		req.act = act;
		req.tag = tag;
		req.prio = prio;
		req.gap = gap;
		req.drain = drain;
		pending_requests.push_back(req);
	endtask

	// Applies one accepted request to the shadow queue and returns its result.
	// A new job goes behind every queued job of equal or more urgent priority.
	function automatic queue_result_t predict_job_queue(action_t act, logic [TAG_W-1:0] tag,
			logic [PRIO_W-1:0] prio);
		queue_result_t r;
		int pos;
		r.status = STATUS_DONE;
		r.tag = '0;
		r.prio = '0;
		if (act == ACTION_INSERT) begin
			if (shadow_count == DEPTH) begin
				r.status = STATUS_OVERFLOW;
			end else begin
				pos = 0;
				while (pos < shadow_count && shadow_prios[pos] <= prio)
					pos++;
				for (int i = shadow_count; i > pos; i--) begin
					shadow_tags[i] = shadow_tags[i-1];
					shadow_prios[i] = shadow_prios[i-1];
				end
				shadow_tags[pos] = tag;
				shadow_prios[pos] = prio;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.status = STATUS_UNDERFLOW;
		end else begin
			r.tag = shadow_tags[0];
			r.prio = shadow_prios[0];
			for (int i = 1; i < shadow_count; i++) begin
				shadow_tags[i-1] = shadow_tags[i];
				shadow_prios[i-1] = shadow_prios[i];
			end
			shadow_count--;
		end
		r.empty = (shadow_count == 0);
		r.full = (shadow_count == DEPTH);
		return r;
	endfunction

	// Request driver: predicts each request as it is taken, then presents the
	// next one after its drawn gap. A request marked drain also waits until
	// every outstanding result has come back.
	always @(posedge clk or negedge arst_n) begin : drive_requests
		job_request_t nxt;
		logic present;
		if (!arst_n) begin
			start <= 1'b0;
			next_armed = 1'b0;
			hold_off = 0;
		end else begin
			if (start && busy === 1'b0)
				expected_results.push_back(predict_job_queue(action_t'(action), job_tag,
					job_priority));
			if (!start || busy === 1'b0) begin
				present = 1'b0;
				if (!next_armed && pending_requests.size() != 0) begin
					hold_off = pending_requests[0].gap;
					next_armed = 1'b1;
				end
				if (next_armed) begin
					if (hold_off != 0) begin
						hold_off--;
					end else if (!pending_requests[0].drain || expected_results.size() == 0) begin
						nxt = pending_requests.pop_front();
						present = 1'b1;
						next_armed = 1'b0;
					end
				end
				if (present) begin
					start <= 1'b1;
					action <= nxt.act;
					job_tag <= nxt.tag;
					job_priority <= nxt.prio;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every done pulse is matched against the oldest expectation.
	always @(posedge clk) begin : check_results
		queue_result_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", status, 0);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (out_tag !== want.tag)
					report_mismatch("out_tag", out_tag, want.tag);
				if (out_priority !== want.prio)
					report_mismatch("out_priority", out_priority, want.prio);
				if (is_empty !== want.empty)
					report_mismatch("is_empty", is_empty, want.empty);
				if (is_full !== want.full)
					report_mismatch("is_full", is_full, want.full);
			end
		end
	end

	initial begin
		int insert_pct;
		int fixed_prio;
		bit burst;
		bit one_prio;
		int guard;
		logic [PRIO_W-1:0] fill_prios[DEPTH];

		fill_prios = '{2, 1, 2, 0, 3, 1, 0, 2};

		// Directed part: underflow, both tag extremes, ordering, overflow, FIFO ties.
		add_request(ACTION_REMOVE, 16'hFFFF, 2'd3, 0, 1'b0);
		add_request(ACTION_INSERT, 16'hFFFF, 2'd3, 0, 1'b0);
		add_request(ACTION_INSERT, 16'h0000, 2'd0, 0, 1'b0);
		add_request(ACTION_REMOVE, 16'h0000, 2'd0, 0, 1'b0);
		add_request(ACTION_REMOVE, 16'h5A5A, 2'd1, 0, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			add_request(ACTION_INSERT, 16'h1000 + 16'(i), fill_prios[i], i % 3, 1'b0);
		add_request(ACTION_INSERT, 16'hABCD, 2'd0, 0, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			add_request(ACTION_REMOVE, 16'hFFFF, 2'd3, i % 2, 1'b0);
		add_request(ACTION_REMOVE, 16'h0000, 2'd0, 0, 1'b0);

		// Random part: segments that lean toward filling or draining the queue,
		// some with a single shared priority, some without any gaps.
		for (int seg = 0; seg < 50; seg++) begin
			case ($urandom_range(0, 3))
				0: insert_pct = 15;
				1: insert_pct = 50;
				2: insert_pct = 85;
				default: insert_pct = 100;
			endcase
			burst = ($urandom_range(0, 3) == 0);
			one_prio = ($urandom_range(0, 4) == 0);
			fixed_prio = $urandom_range(0, 3);
			for (int k = 0; k < 20; k++)
				add_request(($urandom_range(1, 100) <= insert_pct) ? ACTION_INSERT : ACTION_REMOVE,
					16'($urandom_range(0, 65535)),
					one_prio ? 2'(fixed_prio) : 2'($urandom_range(0, 3)),
					burst ? 0 : $urandom_range(0, 7),
					k == 0 && seg % 8 == 0);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sample between edges so that the driver's updates have settled.
		while (pending_requests.size() != 0 || next_armed || start)
			@(negedge clk);
		guard = 0;
		while (expected_results.size() != 0 && guard < 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (DEPTH + 4) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("results never arrived, count", expected_results.size(), 0);

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
sv/bpjq_pkg.sv
sv/bpjq_ctrl.sv
sv/bpjq_dp.sv
sv/bounded_priority_job_queue_unit.sv
test/testbench.sv
